[rtl/base64url_padded_encoder_core_macros.svh]
// Assertion macros shared by the base64url encoder RTL.
`ifndef BASE64URL_PADDED_ENCODER_CORE_MACROS_SVH
`define BASE64URL_PADDED_ENCODER_CORE_MACROS_SVH

// Plain property check, sampled on clk, off while in reset.
`define B64U_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define B64U_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check.
`define B64U_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/b64u_pkg.sv]
// Package: word types, group result type and alphabet mapping for the base64url encoder.
`default_nettype none

package b64u_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
	} out_word_t;

	// Position of the next byte inside its three-byte group.
	typedef enum logic [1:0] {
		PH0 = 2'd0,
		PH1 = 2'd1,
		PH2 = 2'd2
	} phase_t;

	localparam int unsigned MaxChars = 4;

	// Characters from one input byte; chars[0] goes out first.
	typedef struct packed {
		logic [MaxChars-1:0][7:0] chars;
		logic [2:0]               cnt;
		logic                     fin;
	} grp_t;

	localparam logic [7:0] PadChar   = 8'h3D; // '='
	localparam logic [7:0] DashChar  = 8'h2D; // '-'
	localparam logic [7:0] UnderChar = 8'h5F; // '_'

	// 6-bit index to URL-safe alphabet character.
	function automatic logic [7:0] enc6(input logic [5:0] v);
		logic [7:0] w;
		begin
			w = {2'b00, v};
			if (v < 6'd26)
				enc6 = w + 8'd65;          // 'A'..'Z'
			else if (v < 6'd52)
				enc6 = w + 8'd71;          // 'a'..'z'  (97 - 26)
			else if (v < 6'd62)
				enc6 = w - 8'd4;           // '0'..'9'  (52 - 48)
			else if (v == 6'd62)
				enc6 = DashChar;
			else
				enc6 = UnderChar;
		end
	endfunction

endpackage

`default_nettype wire

[rtl/b64u_group.sv]
// Group tracker: phase/carry state and the characters one byte yields.
`default_nettype none

module b64u_group (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire b64u_pkg::in_word_t word_s1,
	input  wire logic             load,
	output b64u_pkg::grp_t        grp
);
	import b64u_pkg::*;

	phase_t     phase_q, phase_d;
	logic [3:0] carry_q, carry_d;
	logic [7:0] b;

	assign b = word_s1.data_byte;

	always_comb begin
		grp.chars = '0;
		grp.cnt   = 3'd1;
		grp.fin   = word_s1.final_byte;
		phase_d   = PH0;
		carry_d   = 4'd0;
		unique case (phase_q)
			PH1: begin
				grp.chars[0] = enc6({carry_q[1:0], b[7:4]});
				if (word_s1.final_byte) begin
					grp.chars[1] = enc6({b[3:0], 2'b00});
					grp.chars[2] = PadChar;
					grp.cnt      = 3'd3;
				end else begin
					phase_d = PH2;
					carry_d = b[3:0];
				end
			end
			PH2: begin
				grp.chars[0] = enc6({carry_q, b[7:6]});
				grp.chars[1] = enc6(b[5:0]);
				grp.cnt      = 3'd2;
			end
			default: begin
				// phase 0, and the unused code treated the same
				grp.chars[0] = enc6(b[7:2]);
				if (word_s1.final_byte) begin
					grp.chars[1] = enc6({b[1:0], 4'b0000});
					grp.chars[2] = PadChar;
					grp.chars[3] = PadChar;
					grp.cnt      = 3'd4;
				end else begin
					phase_d = PH1;
					carry_d = {2'b00, b[1:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH0;
			carry_q <= 4'd0;
		end else if (load) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

endmodule

`default_nettype wire

[rtl/b64u_outbuf.sv]
// Result register: holds up to four characters and shifts them out one per word.
`default_nettype none
`include "base64url_padded_encoder_core_macros.svh"

module b64u_outbuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire b64u_pkg::grp_t    grp,
	output logic                   can_load,
	output logic                   enc_valid,
	input  wire logic              enc_ready,
	output b64u_pkg::out_word_t    enc_word
);
	import b64u_pkg::*;

	logic [MaxChars-1:0][7:0] chars_q;
	logic [2:0]               cnt_q;
	logic                     fin_q;
	logic                     fire;

	assign enc_valid          = (cnt_q != 3'd0);
	assign fire               = enc_valid && enc_ready;
	assign can_load           = (cnt_q == 3'd0) || (cnt_q == 3'd1 && enc_ready);
	assign enc_word.out_char  = chars_q[0];
	assign enc_word.last_char = fin_q && (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			fin_q <= 1'b0;
		end else if (load) begin
			cnt_q <= grp.cnt;
			fin_q <= grp.fin;
		end else if (fire) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= grp.chars;
		end else if (fire) begin
			chars_q <= {8'h00, chars_q[MaxChars-1:1]};
		end
	end

	`B64U_ASSERT(a_cnt_range, cnt_q <= 3'd4, "char count out of range")
	`B64U_ASSERT_IMPL(a_load_room, load, can_load, "group loaded over pending chars")
	`B64U_ASSERT_NEXT(a_load_nonempty, load, cnt_q != 3'd0, "loaded group left buffer empty")
	`B64U_ASSERT_NEXT(a_drain, fire && cnt_q == 3'd1 && !load, cnt_q == 3'd0,
		"buffer did not drain after last char")

endmodule

`default_nettype wire

[rtl/base64url_padded_encoder_core.sv]
// Top level: base64url encoder with '=' padding, one input byte per word, one char per word.
// Path: an accepted byte is held in the input register, then loaded into the result register that drives enc_*.
// Output: a byte yields as many characters as its group position gives (1, 2, or up to 4 on a final
//   byte); three bytes yield four characters, which go out one per word as enc_ready allows.
// Reset: arst_n async low clears group phase, carry bits and all valid/count state.
`default_nettype none
`include "base64url_padded_encoder_core_macros.svh"

module base64url_padded_encoder_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// byte input
	input  wire logic                src_valid,
	output logic                     src_ready,
	input  wire b64u_pkg::in_word_t  src_word,
	// character output
	output logic                     enc_valid,
	input  wire logic                enc_ready,
	output b64u_pkg::out_word_t      enc_word
);
	import b64u_pkg::*;

	// Input register: holds the next byte while the result register drains.
	logic     valid_s1;
	in_word_t word_s1;
	logic     load;
	logic     can_load;
	grp_t     grp;

	// A byte moves into the result register once the previous characters are
	// gone (or the last one is leaving this cycle), so single-char bytes
	// stream at one per cycle while enc_ready stays high.
	assign load      = valid_s1 && can_load;
	assign src_ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			word_s1 <= src_word;
		end
	end

	// Phase/carry tracking and the character mapping for the held byte.
	b64u_group u_group (
		.clk     (clk),
		.arst_n  (arst_n),
		.word_s1 (word_s1),
		.load    (load),
		.grp     (grp)
	);

	// Result register and character shifter.
	b64u_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.grp       (grp),
		.can_load  (can_load),
		.enc_valid (enc_valid),
		.enc_ready (enc_ready),
		.enc_word  (enc_word)
	);

	`B64U_ASSERT_NEXT(a_hold_s1, valid_s1 && !load, valid_s1 && $stable(word_s1),
		"held byte dropped or changed before load")
	`B64U_ASSERT_NEXT(a_take_s1, src_valid && src_ready, valid_s1,
		"accepted byte not captured")
	`B64U_ASSERT_IMPL(a_ready_free, !valid_s1, src_ready,
		"input stalled with empty input register")

endmodule

`default_nettype wire
